// File: src/tecf_pkg.sv
// Shared codes and default widths for the triangle edge crossing finder.
package tecf_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int SKIP_WIDTH          = 2;
   localparam int MASK_WIDTH          = 3;
   localparam int CORNER_WIDTH        = 2;
   localparam int INT_BITS            = 8;

   localparam logic [SKIP_WIDTH-1:0] SKIP_NONE = 2'd0;
   localparam logic [SKIP_WIDTH-1:0] SKIP_V1V2 = 2'd1;
   localparam logic [SKIP_WIDTH-1:0] SKIP_V2V3 = 2'd2;
   localparam logic [SKIP_WIDTH-1:0] SKIP_V3V1 = 2'd3;

   localparam logic [CORNER_WIDTH-1:0] CORNER_V1 = 2'd0;
   localparam logic [CORNER_WIDTH-1:0] CORNER_V2 = 2'd1;
   localparam logic [CORNER_WIDTH-1:0] CORNER_V3 = 2'd2;

   typedef logic [MASK_WIDTH-1:0]   mask_type;
   typedef logic [CORNER_WIDTH-1:0] corner_type;
   typedef logic [SKIP_WIDTH-1:0]   skip_type;

endpackage

// File: src/triangle_edge_crossing_finder_core.sv
// Top level: pipelined segment versus triangle edge crossing finder.
//
// Channel  Dir  Beat contents
// req_     in   tdata: src_u src_v src_w dst_u dst_v dst_w; tuser: skip_edge
// rsp_     out  tdata: cross_u cross_v cross_w; tuser: found hit_mask free_corner
//
// One beat in and one beat out per cycle while the output is not stalled;
// the restoring divider produces one quotient bit per stage.
// Reset (synchronous, active high) clears every stage valid bit.
// A stalled output holds the whole pipeline; no beat is lost or repeated.
module triangle_edge_crossing_finder_core #(
   parameter int COORD_WIDTH = tecf_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // src_u, src_v, src_w, dst_u, dst_v, dst_w (low to high), zero padded
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // skip_edge
   input  tecf_pkg::skip_type req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // cross_u, cross_v, cross_w (low to high), zero padded
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // found, hit_mask[2:0], free_corner[1:0] (low to high)
   output logic [5:0] rsp_tuser
);
   import tecf_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int F  = W - INT_BITS;
   localparam int DW = W + 3;
   localparam int MW = W + 2;
   localparam int PW = 2 * W + 4;
   localparam int Q  = W + 2;
   localparam int OW = ((3*W+7)/8)*8;
   localparam logic signed [DW-1:0] ONE_Q = DW'(1) <<< F;

   function automatic logic [PW-1:0] mag_p(input logic signed [PW-1:0] x);
      return x[PW-1] ? PW'(-x) : PW'(x);
   endfunction

   function automatic logic unit_ok(input logic signed [PW-1:0] n,
                                    input logic signed [DW-1:0] d, input int sh);
      logic [PW-1:0] lim;
      lim = mag_p(PW'(d)) << sh;
      return ((n == '0) || (n[PW-1] == d[DW-1])) && (mag_p(n) <= lim);
   endfunction

   logic ce;
   assign ce = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;

   // stage A: differences and cross products
   logic signed [W-1:0]    in_s [3];
   logic signed [W-1:0]    in_e [3];
   logic signed [DW-1:0]   s_in [3];
   logic signed [DW-1:0]   d_in [3];
   logic signed [DW-1:0]   den_in [3];
   logic signed [DW-1:0]   n2_in [3];
   logic signed [2*W-1:0]  p10_in, p01_in;

   logic                   a_vld_ff;
   skip_type               a_skip_ff;
   logic signed [DW-1:0]   a_s_ff [3];
   logic signed [DW-1:0]   a_d_ff [3];
   logic signed [DW-1:0]   a_den_ff [3];
   logic signed [DW-1:0]   a_n2_ff [3];
   logic signed [2*W-1:0]  a_p10_ff, a_p01_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_s[i] = req_tdata[i*W +: W];
         in_e[i] = req_tdata[(3+i)*W +: W];
         s_in[i] = DW'(in_s[i]);
         d_in[i] = DW'(in_e[i]) - DW'(in_s[i]);
      end
      den_in[0] = s_in[0] + s_in[1] - DW'(in_e[0]) - DW'(in_e[1]);
      den_in[1] = s_in[0] - DW'(in_e[0]);
      den_in[2] = s_in[1] - DW'(in_e[1]);
      n2_in[0]  = s_in[0] + s_in[1] - ONE_Q;
      n2_in[1]  = s_in[0];
      n2_in[2]  = s_in[1];
      p10_in    = (2*W)'(in_e[1]) * (2*W)'(in_s[0]);
      p01_in    = (2*W)'(in_e[0]) * (2*W)'(in_s[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (ce) begin
         a_vld_ff <= req_tvalid;
      end
      if (ce) begin
         a_skip_ff <= req_tuser;
         a_s_ff    <= s_in;
         a_d_ff    <= d_in;
         a_den_ff  <= den_in;
         a_n2_ff   <= n2_in;
         a_p10_ff  <= p10_in;
         a_p01_ff  <= p01_in;
      end
   end

   // stage B: edge parameter numerators
   logic signed [PW-1:0] cr;
   logic signed [PW-1:0] n1_in [3];

   logic                 b_vld_ff;
   skip_type             b_skip_ff;
   logic signed [DW-1:0] b_s_ff [3];
   logic signed [DW-1:0] b_d_ff [3];
   logic signed [DW-1:0] b_den_ff [3];
   logic signed [DW-1:0] b_n2_ff [3];
   logic signed [PW-1:0] b_n1_ff [3];

   always_comb begin
      cr       = PW'(a_p10_ff) - PW'(a_p01_ff);
      n1_in[0] = cr + (PW'(a_den_ff[2]) <<< F);
      n1_in[1] = (PW'(a_den_ff[1]) <<< F) - cr;
      n1_in[2] = -cr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (ce) begin
         b_vld_ff <= a_vld_ff;
      end
      if (ce) begin
         b_skip_ff <= a_skip_ff;
         b_s_ff    <= a_s_ff;
         b_d_ff    <= a_d_ff;
         b_den_ff  <= a_den_ff;
         b_n2_ff   <= a_n2_ff;
         b_n1_ff   <= n1_in;
      end
   end

   // stage C: range tests, keep the last edge hit
   mask_type             hit_in;
   logic signed [DW-1:0] sel_n2_in, sel_den_in;
   corner_type           corner_in;

   logic                 c_vld_ff;
   skip_type             c_skip_ff;
   mask_type             c_mask_ff;
   corner_type           c_corner_ff;
   logic signed [DW-1:0] c_n2_ff, c_den_ff;
   logic signed [DW-1:0] c_s_ff [3];
   logic signed [DW-1:0] c_d_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hit_in[k] = (b_skip_ff != SKIP_WIDTH'(k + 1)) && (b_den_ff[k] != '0) &&
                     unit_ok(b_n1_ff[k], b_den_ff[k], F) &&
                     unit_ok(PW'(b_n2_ff[k]), b_den_ff[k], 0);
      end
      sel_n2_in  = b_n2_ff[0];
      sel_den_in = b_den_ff[0];
      corner_in  = CORNER_V3;
      if (hit_in[2]) begin
         sel_n2_in  = b_n2_ff[2];
         sel_den_in = b_den_ff[2];
         corner_in  = CORNER_V2;
      end else if (hit_in[1]) begin
         sel_n2_in  = b_n2_ff[1];
         sel_den_in = b_den_ff[1];
         corner_in  = CORNER_V1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (ce) begin
         c_vld_ff <= b_vld_ff;
      end
      if (ce) begin
         c_skip_ff   <= b_skip_ff;
         c_mask_ff   <= hit_in;
         c_corner_ff <= corner_in;
         c_n2_ff     <= sel_n2_in;
         c_den_ff    <= sel_den_in;
         c_s_ff      <= b_s_ff;
         c_d_ff      <= b_d_ff;
      end
   end

   // divider: entry 0 holds the products, each later entry one quotient bit
   logic                   dv_vld_ff    [Q+1];
   mask_type               dv_mask_ff   [Q+1];
   corner_type             dv_corner_ff [Q+1];
   logic [MW-1:0]          dv_den_ff    [Q+1];
   logic [PW-1:0]          dv_r_ff      [Q+1][3];
   logic [Q-1:0]           dv_q_ff      [Q+1][3];
   logic                   dv_neg_ff    [Q+1][3];
   logic signed [W-1:0]    dv_s_ff      [Q+1][3];

   logic [MW-1:0] mag_n2, mag_den;
   logic [MW-1:0] mag_d [3];

   always_comb begin
      mag_n2  = c_n2_ff[DW-1]  ? MW'(-c_n2_ff)  : MW'(c_n2_ff);
      mag_den = c_den_ff[DW-1] ? MW'(-c_den_ff) : MW'(c_den_ff);
      for (int i = 0; i < 3; i++) begin
         mag_d[i] = c_d_ff[i][DW-1] ? MW'(-c_d_ff[i]) : MW'(c_d_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (ce) begin
         dv_vld_ff[0] <= c_vld_ff;
      end
      if (ce) begin
         dv_mask_ff[0]   <= c_mask_ff;
         dv_corner_ff[0] <= c_corner_ff;
         dv_den_ff[0]    <= mag_den;
         for (int i = 0; i < 3; i++) begin
            dv_r_ff[0][i]   <= PW'(mag_n2) * PW'(mag_d[i]);
            dv_q_ff[0][i]   <= '0;
            dv_neg_ff[0][i] <= c_n2_ff[DW-1] ^ c_d_ff[i][DW-1] ^ c_den_ff[DW-1];
            dv_s_ff[0][i]   <= W'(c_s_ff[i]);
         end
      end
   end

   for (genvar j = 0; j < Q; j++) begin : g_div
      localparam int K = Q - 1 - j;
      logic [PW-1:0] sh;
      logic [PW-1:0] r_in [3];
      logic [Q-1:0]  q_in [3];

      always_comb begin
         sh = PW'(dv_den_ff[j]) << K;
         for (int i = 0; i < 3; i++) begin
            r_in[i] = dv_r_ff[j][i];
            q_in[i] = dv_q_ff[j][i];
            if (dv_r_ff[j][i] >= sh) begin
               r_in[i]    = dv_r_ff[j][i] - sh;
               q_in[i][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j+1] <= 1'b0;
         end else if (ce) begin
            dv_vld_ff[j+1] <= dv_vld_ff[j];
         end
         if (ce) begin
            dv_mask_ff[j+1]   <= dv_mask_ff[j];
            dv_corner_ff[j+1] <= dv_corner_ff[j];
            dv_den_ff[j+1]    <= dv_den_ff[j];
            dv_r_ff[j+1]      <= r_in;
            dv_q_ff[j+1]      <= q_in;
            dv_neg_ff[j+1]    <= dv_neg_ff[j];
            dv_s_ff[j+1]      <= dv_s_ff[j];
         end
      end
   end

   // output stage: sign, add start point, saturate, zero the payload on a miss
   logic signed [DW-1:0] qs, sum;
   logic signed [W-1:0]  cross_in [3];

   logic                 o_vld_ff;
   mask_type             o_mask_ff;
   corner_type           o_corner_ff;
   logic signed [W-1:0]  o_cross_ff [3];

   always_comb begin
      qs  = '0;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         qs  = dv_neg_ff[Q][i] ? -DW'(dv_q_ff[Q][i]) : DW'(dv_q_ff[Q][i]);
         sum = DW'(dv_s_ff[Q][i]) + qs;
         if ((sum[DW-1:W-1] == '0) || (sum[DW-1:W-1] == '1)) begin
            cross_in[i] = W'(sum);
         end else begin
            cross_in[i] = {sum[DW-1], {(W-1){~sum[DW-1]}}};
         end
         if (dv_mask_ff[Q] == '0) begin
            cross_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (ce) begin
         o_vld_ff <= dv_vld_ff[Q];
      end
      if (ce) begin
         o_mask_ff   <= dv_mask_ff[Q];
         o_corner_ff <= (dv_mask_ff[Q] == '0) ? CORNER_V1 : dv_corner_ff[Q];
         o_cross_ff  <= cross_in;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = OW'({o_cross_ff[2], o_cross_ff[1], o_cross_ff[0]});
   assign rsp_tuser  = {o_corner_ff, o_mask_ff, (o_mask_ff != '0)};

   a_skip_no_hit: assert property (@(posedge clock) disable iff (reset)
      (c_vld_ff && c_skip_ff == SKIP_V1V2) |-> !c_mask_ff[0])
      else $error("skipped edge V1V2 reported as hit");

   a_corner_last: assert property (@(posedge clock) disable iff (reset)
      (c_vld_ff && c_mask_ff[2]) |-> (c_corner_ff == CORNER_V2))
      else $error("corner does not follow last edge hit");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3:1] == '0) |->
         (rsp_tdata == '0 && rsp_tuser[5:4] == CORNER_V1))
      else $error("miss beat carries nonzero payload");

   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output valid right after reset");

endmodule
